// File: sv/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 engine.
`default_nettype none
package sha_pkg;
	localparam int unsigned QDepth = 4;

	typedef enum logic [0:0] {
		KIND_DATA   = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] init_vec(input logic [2:0] i);
		logic [31:0] r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
		return (v >> s) | (v << (32 - s));
	endfunction
endpackage
`default_nettype wire

// File: sv/sha_front_fifo.sv
// Front queue: accepts input beats and buffers them for the compression core.
`default_nettype none
module sha_front_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire sha_pkg::beat_t in_beat,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      sha_pkg::beat_t out_beat
);
	localparam int unsigned AW = $clog2(sha_pkg::QDepth);
	sha_pkg::beat_t   mem_q [sha_pkg::QDepth];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(sha_pkg::QDepth));
	assign out_valid = (cnt_q != '0);
	assign out_beat  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(sha_pkg::QDepth)) else $error("queue overflow");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop on empty");
endmodule
`default_nettype wire

// File: sv/sha_core.sv
// Back end: block buffer, padding, 64-round compression and digest output.
`default_nettype none
module sha_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire sha_pkg::beat_t in_beat,
	output      logic           valid,
	input  wire logic           ready,
	output      logic [31:0]    digest_word,
	output      logic [2:0]     word_index,
	output      logic           last_word
);
	sha_pkg::state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oi_q;
	logic        fin_q;
	logic        second_q;
	logic [5:0]  pos;
	logic [3:0]  widx;
	logic [7:0]  byte_in;
	logic [31:0] t1, t2, s0, s1, wn, wcur;

	assign pos = bits_q[8:3];
	assign widx = pos[5:2];
	assign byte_in = (in_beat.kind == sha_pkg::KIND_DATA) ? in_beat.data : sha_pkg::PadByte;
	assign in_ready = (state_q == sha_pkg::ST_IDLE);
	assign valid = (state_q == sha_pkg::ST_EMIT);
	assign digest_word = h_q[oi_q];
	assign word_index = oi_q;
	assign last_word = (oi_q == 3'd7);

	always_comb begin
		wcur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wn;
		s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11)
			^ sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::RoundK[rnd_q] + wcur;
		t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_beat.kind == sha_pkg::KIND_FINISH) state_d = sha_pkg::ST_PAD;
					else if (pos == 6'd63) state_d = sha_pkg::ST_LOAD;
				end
			end
			sha_pkg::ST_PAD:   state_d = sha_pkg::ST_LOAD;
			sha_pkg::ST_LOAD:  state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha_pkg::ST_FOLD;
			sha_pkg::ST_FOLD: begin
				if (!fin_q) state_d = sha_pkg::ST_IDLE;
				else if (second_q) state_d = sha_pkg::ST_PAD;
				else state_d = sha_pkg::ST_EMIT;
			end
			sha_pkg::ST_EMIT:  if (ready && oi_q == 3'd7) state_d = sha_pkg::ST_IDLE;
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and buffer
	always_ff @(posedge clk) begin
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (pos[1:0])
						2'd0: w_q[widx] <= {byte_in, 24'h000000};
						2'd1: w_q[widx][23:16] <= byte_in;
						2'd2: w_q[widx][15:8] <= byte_in;
						default: w_q[widx][7:0] <= byte_in;
					endcase
					if (in_beat.kind == sha_pkg::KIND_FINISH) begin
						for (int i = 0; i < 16; i++) begin
							if (4'(i) > widx) w_q[i] <= '0;
						end
					end
				end
			end
			sha_pkg::ST_PAD: begin
				if (!second_q) begin
					w_q[14] <= bits_q[63:32];
					w_q[15] <= bits_q[31:0];
				end
			end
			sha_pkg::ST_LOAD: begin
				rnd_q <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			sha_pkg::ST_ROUND: begin
				if (rnd_q >= 6'd16) begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
				end else if (rnd_q == 6'd15) begin
					// keep window aligned: slide begins once schedule is needed
				end
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				rnd_q <= rnd_q + 1'b1;
			end
			sha_pkg::ST_FOLD: begin
				if (fin_q && second_q) begin
					for (int i = 0; i < 14; i++) w_q[i] <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_vec(3'(i));
			bits_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			oi_q <= '0;
		end else begin
			unique case (state_q)
				sha_pkg::ST_IDLE: begin
					oi_q <= '0;
					if (in_valid && in_beat.kind == sha_pkg::KIND_DATA) begin
						bits_q <= bits_q + 64'd8;
						fin_q <= 1'b0;
						second_q <= 1'b0;
					end else if (in_valid) begin
						fin_q <= 1'b1;
						second_q <= (pos > 6'd55);
					end
				end
				sha_pkg::ST_PAD: ;
				sha_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					second_q <= 1'b0;
				end
				sha_pkg::ST_EMIT: begin
					if (ready) begin
						oi_q <= oi_q + 1'b1;
						if (oi_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_vec(3'(i));
							bits_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_emit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> fin_q) else $error("emit without finish");
	a_round_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND && rnd_q == 6'd63) |=> state_q == sha_pkg::ST_FOLD)
		else $error("round count");
	a_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && last_word) |=> bits_q == '0) else $error("length not cleared");
endmodule
`default_nettype wire

// File: sv/sha256_digest_engine_unit.sv
// Top level of the streaming SHA-256 engine: front queue and compression core.
// A data beat that fills a block sends the core through load, 64 rounds and fold,
// done by the single round unit; only then is the next beat taken.
// Finish adds one or two blocks, each with a pad step first, then eight output beats.
// The input queue holds four beats, so the source can queue that many during a block.
// Asynchronous active-low reset restores the initial vector and a zero length.
`default_nettype none
module sha256_digest_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] digest_word,
	output      logic [2:0]  word_index,
	output      logic        last_word
);
	sha_pkg::beat_t in_beat, q_beat;
	logic q_valid, q_ready;

	assign in_beat.kind = sha_pkg::kind_t'(kind);
	assign in_beat.data = data_byte;

	sha_front_fifo u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
		.out_valid(q_valid), .out_ready(q_ready), .out_beat(q_beat)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_beat(q_beat),
		.valid(out_valid), .ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);
endmodule
`default_nettype wire

// File: tb/sv/sha256_digest_engine_unit_tb.sv
// Self-checking testbench for the SHA-256 engine: byte and finish beats in, digest words out.
`default_nettype none
module sha256_digest_engine_unit_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	logic [31:0]  hash_state [8];
	logic [7:0]   msg_block [64];
	logic [63:0]  msg_bits;
	digest_beat_t digest_q [$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  recv_hold = 1'b0;
	bit  failed = 1'b0;
	int  quiet_cycles = 0;

	sha256_digest_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, e, a;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			e = v[4];
			a = v[0];
			t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ KTAB[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
				+ ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic hash_reset();
		for (int i = 0; i < 8; i++)
			hash_state[i] = IV[i];
		for (int i = 0; i < 64; i++)
			msg_block[i] = 8'h00;
		msg_bits = 64'd0;
	endtask

	task automatic predict_beat(input sha_pkg::kind_t k, input logic [7:0] b);
		int pos;
		digest_beat_t d;
		pos = int'(msg_bits[8:3]);
		if (k == sha_pkg::KIND_DATA) begin
			msg_block[pos] = b;
			msg_bits += 64'd8;
			if (pos == 63)
				compress_msg_block();
		end else begin
			msg_block[pos] = sha_pkg::PadByte;
			pos++;
			if (pos > 56) begin
				for (int i = pos; i < 64; i++)
					msg_block[i] = 8'h00;
				compress_msg_block();
				pos = 0;
			end
			for (int i = pos; i < 56; i++)
				msg_block[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				msg_block[63-i] = msg_bits[8*i +: 8];
			compress_msg_block();
			for (int i = 0; i < 8; i++) begin
				d.word = hash_state[i];
				d.idx = 3'(i);
				d.last = (i == 7);
				digest_q.push_back(d);
			end
			hash_reset();
		end
	endtask

	task automatic send_beat(input sha_pkg::kind_t k, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			kind <= sha_pkg::kind_t'($urandom_range(1));
			data_byte <= 8'($urandom);
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_beat(k, b);
		@(negedge clk);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		kind <= sha_pkg::kind_t'($urandom_range(1));
		data_byte <= 8'($urandom);
		@(negedge clk);
	endtask

	task automatic send_bytes(input int n);
		for (int i = 0; i < n; i++)
			send_beat(sha_pkg::KIND_DATA, 8'($urandom));
	endtask

	task automatic drain();
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		digest_beat_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest beat got %h/%0d/%0d", $time,
					digest_word, word_index, last_word);
				failed = 1'b1;
			end else begin
				exp_b = digest_q.pop_front();
				if (digest_word !== exp_b.word || word_index !== exp_b.idx
						|| last_word !== exp_b.last) begin
					$display("%0t: digest mismatch exp %h/%0d/%0d got %h/%0d/%0d", $time,
						exp_b.word, exp_b.idx, exp_b.last, digest_word, word_index, last_word);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_directed();
		send_beat(sha_pkg::KIND_FINISH, 8'hff);
		send_beat(sha_pkg::KIND_DATA, 8'h00);
		send_beat(sha_pkg::KIND_FINISH, 8'h00);
		send_beat(sha_pkg::KIND_DATA, 8'hff);
		send_beat(sha_pkg::KIND_DATA, 8'h80);
		send_beat(sha_pkg::KIND_DATA, 8'h7f);
		send_beat(sha_pkg::KIND_FINISH, 8'h55);
		end_burst();
	endtask

	task automatic test_pad_edges();
		send_bytes(119);
		send_beat(sha_pkg::KIND_FINISH, 8'h00);
		send_bytes(56);
		send_beat(sha_pkg::KIND_FINISH, 8'h00);
		end_burst();
	endtask

	task automatic test_random_msgs(input int beats);
		int sent;
		int len;
		sent = 0;
		while (sent < beats) begin
			len = $urandom_range(10);
			send_bytes(len);
			send_beat(sha_pkg::KIND_FINISH, 8'($urandom));
			sent += len + 1;
		end
		end_burst();
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(negedge clk);
				recv_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 6; i++)
					send_beat(sha_pkg::KIND_FINISH, 8'($urandom));
				end_burst();
			end
		join
		drain();
	endtask

	initial begin
		hash_reset();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		drain();
		test_pad_edges();
		drain();
		test_backpressure();
		test_random_msgs(8);
		send_idle_pct = 77;
		test_random_msgs(8);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		test_random_msgs(8);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		test_random_msgs(8);
		drain();
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
